### src/bvald_pkg.sv
// ----------------------------------------------------------------------------
// Battery voltage averager package
// Widths, thresholds and shared types for the averager and its divider.
// ----------------------------------------------------------------------------
package bvald_pkg;

   localparam int RING_DEPTH  = 16;
   localparam int SLOT_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int SAMPLE_W    = 16;
   localparam int CNT_W       = $clog2(RING_DEPTH + 1);
   localparam int CNT_OUT_W   = 5;
   localparam int SUM_W       = SAMPLE_W + $clog2(RING_DEPTH);
   localparam int CELL_W      = 13;
   localparam int PROD_W      = 15 + CNT_W;
   localparam int CMP_W       = (SUM_W > PROD_W) ? SUM_W : PROD_W;
   localparam int REM_W       = CNT_W + 1;
   localparam int DIV_CNT_W   = $clog2(SUM_W + 1);

   localparam logic [SAMPLE_W-1:0] VALID_FLOOR_MV      = SAMPLE_W'(500);
   localparam logic [CMP_W-1:0]    USB_LIMIT_MV        = CMP_W'(6000);
   localparam logic [CMP_W-1:0]    TWO_CELL_LIMIT_MV   = CMP_W'(9000);
   localparam logic [CMP_W-1:0]    THREE_CELL_LIMIT_MV = CMP_W'(14000);
   localparam logic [CELL_W-1:0]   MIN_CELL_RESET_MV   = CELL_W'(3300);

   // divider result toward the sequencer
   typedef struct packed {
      logic             done;
      logic [SUM_W-1:0] quotient;
   } div_result_type;

endpackage

### src/battery_voltage_average_low_detect_core.sv
// ----------------------------------------------------------------------------
// Battery voltage average and low-battery detect
// Ring of recent readings, running sum and count, mean and low flag.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one reading in millivolts per beat. Each beat overwrites the
//   oldest entry of a 16-entry sample ring and yields one rsp beat with the
//   truncated mean of the readings above 500 mV, their count and a low-battery
//   flag judged from the exact mean against the cell thresholds.
//   csr_wr_en/csr_wr_data write the minimum cell voltage (reset 3300 mV);
//   write it only while no beat is in flight.
// Steps:
//   From request beat to response beat: read the ring entry, update the
//   running sum, scale the thresholds, run the serial divider (one quotient
//   bit per cycle over the 20-bit sum) and load the output register. One
//   reading at a time: a new request is taken only once the previous result
//   has been loaded into the output register.
// Reset:
//   Synchronous. The ring reads as all zero through per-entry valid bits,
//   the sum, count and write slot clear, and no response is pending.
// Stall:
//   The output register holds a finished beat while rsp_tready is low; the
//   next request is still taken and runs until its result waits for the
//   output register to free up.
// ----------------------------------------------------------------------------
module battery_voltage_average_low_detect_core
   import bvald_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [15:0]       req_tdata,   // [15:0] sample_mv
   // response channel
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [23:0]       rsp_tdata,   // [15:0] average_mv, [20:16] valid_count,
                                          // [21] low_battery, [23:22] zero
   // configuration
   input  logic              csr_wr_en,
   input  logic [CELL_W-1:0] csr_wr_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_SCALE,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   state_type            state_ff;

   // sample ring: memory plus per-entry valid bits for the cleared reset state
   logic [SAMPLE_W-1:0]  ring_mem [RING_DEPTH];
   logic [RING_DEPTH-1:0] ring_live_ff;
   logic [SAMPLE_W-1:0]  rd_data_ff;
   logic                 rd_live_ff;

   logic [SLOT_W-1:0]    slot_ff;
   logic [SAMPLE_W-1:0]  sample_ff;
   logic [SUM_W-1:0]     sum_ff;
   logic [CNT_W-1:0]     total_ff;
   logic [CELL_W-1:0]    min_cell_ff;

   logic [CMP_W-1:0]     t6_ff;
   logic [CMP_W-1:0]     t9_ff;
   logic [CMP_W-1:0]     t14_ff;
   logic [CMP_W-1:0]     t2c_ff;
   logic [CMP_W-1:0]     t3c_ff;

   logic [SAMPLE_W-1:0]  avg_ff;
   logic                 low_ff;

   logic                 rsp_tvalid_ff;
   logic [23:0]          rsp_tdata_ff;

   logic                 req_accept;
   logic [SAMPLE_W-1:0]  old_mv;
   logic [SUM_W-1:0]     sum_in;
   logic [CNT_W-1:0]     total_in;
   logic [CMP_W-1:0]     sum_wide;
   logic                 low_in;
   logic                 div_start;
   div_result_type       div_res;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign div_start  = (state_ff == ST_SCALE);

   // ring memory: write the new reading and read the old one at the same slot
   always_ff @(posedge clock) begin
      if (req_accept) begin
         ring_mem[slot_ff] <= req_tdata;
      end
      rd_data_ff <= ring_mem[slot_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_live_ff <= '0;
         rd_live_ff   <= 1'b0;
      end else begin
         rd_live_ff <= ring_live_ff[slot_ff];
         if (req_accept) begin
            ring_live_ff[slot_ff] <= 1'b1;
         end
      end
   end

   // drop the old reading and add the new one, each only if above the floor
   always_comb begin
      old_mv   = rd_live_ff ? rd_data_ff : '0;
      sum_in   = sum_ff;
      total_in = total_ff;
      if (old_mv > VALID_FLOOR_MV) begin
         sum_in   = sum_in - SUM_W'(old_mv);
         total_in = total_in - 1'b1;
      end
      if (sample_ff > VALID_FLOOR_MV) begin
         sum_in   = sum_in + SUM_W'(sample_ff);
         total_in = total_in + 1'b1;
      end
   end

   // judge the exact mean by comparing the sum against scaled thresholds
   always_comb begin
      sum_wide = CMP_W'(sum_ff);
      if (total_ff == '0 || sum_ff == '0) begin
         low_in = 1'b0;
      end else if (sum_wide < t6_ff) begin
         low_in = 1'b1;
      end else if (sum_wide > t6_ff && sum_wide < t9_ff) begin
         low_in = (sum_wide < t2c_ff);
      end else if (sum_wide > t9_ff && sum_wide < t14_ff) begin
         low_in = (sum_wide < t3c_ff);
      end else begin
         low_in = 1'b1;
      end
   end

   bvald_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (total_ff),
      .result   (div_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         min_cell_ff <= MIN_CELL_RESET_MV;
      end else if (csr_wr_en) begin
         min_cell_ff <= csr_wr_data;
      end
   end

   // sequencer: state, running sum, count, write slot and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         slot_ff       <= '0;
         sum_ff        <= '0;
         total_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         // drop a taken beat unless the done step reloads the register
         if (rsp_tvalid_ff && rsp_tready && state_ff != ST_DONE) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  sample_ff <= req_tdata;
                  state_ff  <= ST_FETCH;
               end
            end
            ST_FETCH: begin
               sum_ff   <= sum_in;
               total_ff <= total_in;
               slot_ff  <= (slot_ff == SLOT_W'(RING_DEPTH - 1)) ? '0 : slot_ff + 1'b1;
               state_ff <= ST_SCALE;
            end
            ST_SCALE: begin
               t6_ff    <= USB_LIMIT_MV * CMP_W'(total_ff);
               t9_ff    <= TWO_CELL_LIMIT_MV * CMP_W'(total_ff);
               t14_ff   <= THREE_CELL_LIMIT_MV * CMP_W'(total_ff);
               t2c_ff   <= CMP_W'({min_cell_ff, 1'b0}) * CMP_W'(total_ff);
               t3c_ff   <= (CMP_W'({min_cell_ff, 1'b0}) + CMP_W'(min_cell_ff))
                           * CMP_W'(total_ff);
               state_ff <= ST_DIVIDE;
            end
            ST_DIVIDE: begin
               if (div_res.done) begin
                  avg_ff   <= (total_ff == '0) ? '0 : SAMPLE_W'(div_res.quotient);
                  low_ff   <= low_in;
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               // hold the result until the output register is free
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tdata_ff  <= {2'b00, low_ff, CNT_OUT_W'(total_ff), avg_ff};
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

`ifndef ASSERT_OFF
   a_total_bounded: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CNT_W'(RING_DEPTH))
      else $error("valid count exceeds ring depth");

   a_empty_sum_zero: assert property (@(posedge clock) disable iff (reset)
      total_ff == '0 |-> sum_ff == '0)
      else $error("nonzero sum with no valid readings");

   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_res.done |-> state_ff == ST_DIVIDE)
      else $error("divider finished outside the divide step");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised without a finished item");
`endif

endmodule

### src/bvald_divider.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division of the valid sum by the valid count, one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
module bvald_divider
   import bvald_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SUM_W-1:0] dividend,
   input  logic [CNT_W-1:0] divisor,
   output div_result_type   result
);

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [REM_W-1:0]     rem_ff;
   logic [SUM_W-1:0]     quo_ff;
   logic [CNT_W-1:0]     div_ff;

   logic [REM_W-1:0]     trial;
   logic                 fits;

   assign trial = {rem_ff[REM_W-2:0], quo_ff[SUM_W-1]};
   assign fits  = (trial >= {1'b0, div_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CNT_W'(SUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         div_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? (trial - {1'b0, div_ff}) : trial;
         quo_ff <= {quo_ff[SUM_W-2:0], fits};
      end
   end

   assign result.done     = done_ff;
   assign result.quotient = quo_ff;

endmodule

### tb/battery_voltage_average_low_detect_core_test.sv
// ----------------------------------------------------------------------------
// Battery voltage average and low-battery detect testbench
// Streams millivolt readings into the core in bursts of random length while
// the response side stalls on its own pattern. Each request beat is run
// through a model of the sample ring, the valid mean and the low flag kept
// here. Each response beat is checked field by field, for several settings of
// the minimum cell voltage.
// ----------------------------------------------------------------------------
module battery_voltage_average_low_detect_core_test;
   import bvald_pkg::*;

   localparam int CLK_HALF       = 4;
   localparam int RESET_CYCLES   = 11;
   localparam int SETTLE_CYCLES  = 40;     // idle time after the last owed response arrives
   localparam int WATCHDOG_LIMIT = 3000;   // cycles with no beat on either side
   localparam int PHASE_COUNT    = 8;
   localparam int PHASE_BEATS    = 190;

   // thresholds of the low-battery judgment, in mV
   localparam longint unsigned FLOOR_MV      = 500;
   localparam longint unsigned USB_MV        = 6000;
   localparam longint unsigned TWO_CELL_MV   = 9000;
   localparam longint unsigned THREE_CELL_MV = 14000;

   // Directed opening, run at the reset value of the cell minimum. The first
   // three readings put the exact mean on 6000, 9000 and 14000 mV. Then come
   // a 500 mV reading (not counted), the smallest counted reading, zero, the
   // top of the range, and readings on either side of the cell limits.
   localparam logic [15:0] DIRECTED_MV [20] = '{
      16'd6000, 16'd12000, 16'd24000, 16'd500, 16'd501, 16'd0, 16'd65535,
      16'd65535, 16'd1, 16'd7000, 16'd6600, 16'd6599, 16'd9900, 16'd9899,
      16'd13999, 16'd14001, 16'd65535, 16'd65535, 16'd5999, 16'd0
   };

   // response beat as laid out on rsp_tdata
   typedef struct packed {
      logic [1:0]  pad;
      logic        low_battery;
      logic [4:0]  valid_count;
      logic [15:0] average_mv;
   } response_t;

   // -------------------------------------------------------------------------
   // Scoreboard: mirror of the ring, the running sum and count, and the cell
   // minimum; holds the responses still owed by the core, oldest first.
   // -------------------------------------------------------------------------
   class battery_average_scoreboard;
      logic [15:0]     ring_mv [RING_DEPTH];
      int unsigned     next_slot;
      longint unsigned valid_sum_mv;
      longint unsigned valid_readings;
      longint unsigned min_cell_mv;
      response_t       owed_averages [$];
      int unsigned     faults;

      function new();
         foreach (ring_mv[i]) ring_mv[i] = '0;
         next_slot      = 0;
         valid_sum_mv   = 0;
         valid_readings = 0;
         min_cell_mv    = 3300;
         faults         = 0;
      endfunction

      function void set_min_cell(logic [CELL_W-1:0] mv);
         min_cell_mv = mv;
      endfunction

      // judge the exact mean by cross-multiplying, never by dividing
      function logic battery_low();
         longint unsigned s;
         longint unsigned n;
         s = valid_sum_mv;
         n = valid_readings;
         if (n == 0 || s == 0) return 1'b0;
         if (s < USB_MV * n) return 1'b1;
         if (s > USB_MV * n && s < TWO_CELL_MV * n)
            return s < 2 * min_cell_mv * n;
         if (s > TWO_CELL_MV * n && s < THREE_CELL_MV * n)
            return s < 3 * min_cell_mv * n;
         return 1'b1;   // exactly 6 V, exactly 9 V, or 14 V and up
      endfunction

      // retire the oldest entry, store the new reading, queue the response
      function void note_reading(logic [15:0] mv);
         response_t want;
         if (ring_mv[next_slot] > FLOOR_MV) begin
            valid_sum_mv   -= ring_mv[next_slot];
            valid_readings -= 1;
         end
         ring_mv[next_slot] = mv;
         if (mv > FLOOR_MV) begin
            valid_sum_mv   += mv;
            valid_readings += 1;
         end
         next_slot = (next_slot + 1) % RING_DEPTH;

         want             = '0;
         want.average_mv  = (valid_readings != 0) ? 16'(valid_sum_mv / valid_readings) : '0;
         want.valid_count = 5'(valid_readings);
         want.low_battery = battery_low();
         owed_averages.push_back(want);
      endfunction

      function void check_result(logic [23:0] beat);
         response_t got;
         response_t want;
         got = beat;
         if (owed_averages.size() == 0) begin
            $error("response beat %h with no reading outstanding", beat);
            faults++;
            return;
         end
         want = owed_averages.pop_front();
         if (got.average_mv !== want.average_mv) begin
            $error("average_mv: expected %0d, got %0d", want.average_mv, got.average_mv);
            faults++;
         end
         if (got.valid_count !== want.valid_count) begin
            $error("valid_count: expected %0d, got %0d", want.valid_count, got.valid_count);
            faults++;
         end
         if (got.low_battery !== want.low_battery) begin
            $error("low_battery: expected %0d, got %0d", want.low_battery, got.low_battery);
            faults++;
         end
         if (got.pad !== want.pad) begin
            $error("pad: expected %0d, got %0d", want.pad, got.pad);
            faults++;
         end
      endfunction

      function int unsigned outstanding();
         return owed_averages.size();
      endfunction

      function bit all_clear();
         if (owed_averages.size() != 0) begin
            $error("%0d responses never arrived", owed_averages.size());
            faults++;
         end
         return faults == 0;
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and core
   // -------------------------------------------------------------------------
   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_tvalid  = 1'b0;
   logic              req_tready;
   logic [15:0]       req_tdata   = '0;    // [15:0] sample_mv
   logic              rsp_tvalid;
   logic              rsp_tready  = 1'b1;
   logic [23:0]       rsp_tdata;           // [15:0] average_mv, [20:16] valid_count,
                                           // [21] low_battery, [23:22] zero
   logic              csr_wr_en   = 1'b0;
   logic [CELL_W-1:0] csr_wr_data = '0;

   battery_average_scoreboard board = new();

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   battery_voltage_average_low_detect_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // -------------------------------------------------------------------------
   // Monitors: sample both channels at the edge, where every input was set by
   // a nonblocking assignment at an earlier edge.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) board.note_reading(req_tdata);
         if (rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);
      end
   end

   // Watchdog: count edges with no beat on either channel; give up at the limit.
   int unsigned quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Response back-pressure: runs of ready or stall of random length, each run's
   // level drawn at random (ready runs up to twice as long as stall runs), drawn independently of the sender.
   int unsigned ready_run   = 0;
   logic        ready_level = 1'b1;

   always @(posedge clock) begin
      if (ready_run == 0) begin
         ready_level = ($urandom_range(99) < 60);
         ready_run   = ready_level ? $urandom_range(60, 1) : $urandom_range(30, 1);
      end
      ready_run   = ready_run - 1;
      rsp_tready <= ready_level;
   end

   // -------------------------------------------------------------------------
   // Driver tasks; each is entered and left right after a rising edge.
   // -------------------------------------------------------------------------

   // Present one reading and hold it until the core takes the beat.
   task automatic send_reading(input logic [15:0] mv);
      req_tvalid <= 1'b1;
      req_tdata  <= mv;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Drop valid for a random gap between bursts; a zero gap keeps valid high
   // so that bursts also run back to back.
   task automatic sender_gap();
      int unsigned gap;
      gap = ($urandom_range(99) < 30) ? 0 : $urandom_range(15, 1);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Hold the sender off until every owed response is in, then let the core
   // settle. The first edge lets the monitor book the last accepted beat.
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the cell minimum; call only while the core is idle.
   task automatic write_min_cell(input logic [CELL_W-1:0] mv);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mv;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.set_min_cell(mv);
   endtask

   // -------------------------------------------------------------------------
   // Reading generation
   // -------------------------------------------------------------------------

   // Pick the voltage a burst hovers around: the fixed thresholds, points below
   // and between them, and the two- and three-cell limits of the current setting.
   function automatic int unsigned draw_centre(int unsigned cell_mv);
      case ($urandom_range(7))
         0:       return 3000;
         1:       return 6000;
         2:       return 7500;
         3:       return 9000;
         4:       return 11500;
         5:       return 14000;
         6:       return 2 * cell_mv;
         default: return 3 * cell_mv;
      endcase
   endfunction

   // Mostly readings near the centre so the mean sits in one band; the rest
   // are near the 500 mV floor, anywhere in range, or exactly on a boundary.
   function automatic logic [15:0] draw_reading(int unsigned centre_mv, int unsigned cell_mv);
      int unsigned pick;
      int unsigned lo;
      int unsigned hi;
      pick = $urandom_range(99);
      if (pick < 60) begin
         lo = (centre_mv > 1500) ? centre_mv - 1500 : 0;
         hi = (centre_mv + 1500 > 65535) ? 65535 : centre_mv + 1500;
         return 16'($urandom_range(hi, lo));
      end
      if (pick < 70) return 16'($urandom_range(600, 0));
      if (pick < 80) return 16'($urandom_range(65535, 0));
      case ($urandom_range(5))
         0:       return 16'(FLOOR_MV);
         1:       return 16'(FLOOR_MV + 1);
         2:       return 16'(USB_MV);
         3:       return 16'(TWO_CELL_MV);
         4:       return 16'(THREE_CELL_MV);
         default: return 16'(2 * cell_mv);
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin : stimulus
      logic [CELL_W-1:0] cell_mv;
      logic [15:0]       reading;
      int unsigned       centre_mv;
      int unsigned       burst_left;
      int unsigned       repeat_left;

      reading   = '0;
      centre_mv = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed readings at the reset setting of the cell minimum
      foreach (DIRECTED_MV[i]) send_reading(DIRECTED_MV[i]);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         // quiesce before touching the register
         drain_responses();
         case (phase)
            0:       cell_mv = '0;
            1:       cell_mv = CELL_W'(5000);
            2:       cell_mv = CELL_W'(4095);
            3:       cell_mv = CELL_W'(3300);
            4, 7:    cell_mv = CELL_W'($urandom_range(5000, 0));
            default: cell_mv = CELL_W'($urandom_range(4700, 2500));
         endcase
         write_min_cell(cell_mv);

         burst_left  = 0;
         repeat_left = 0;
         for (int n = 0; n < PHASE_BEATS; n++) begin
            if (burst_left == 0) begin
               sender_gap();
               burst_left = $urandom_range(20, 1);
               centre_mv  = draw_centre(cell_mv);
               // now and then wait for the pipe to empty mid-phase
               if ($urandom_range(99) < 3) drain_responses();
            end
            // runs of one value long enough to fill the ring land the mean exactly on it
            if (repeat_left != 0) begin
               repeat_left--;
            end else begin
               reading = draw_reading(centre_mv, cell_mv);
               if ($urandom_range(99) < 15) repeat_left = $urandom_range(24, 1);
            end
            send_reading(reading);
            burst_left--;
         end
      end

      drain_responses();
      if (board.all_clear()) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

### sim.f
src/bvald_pkg.sv
src/bvald_divider.sv
src/battery_voltage_average_low_detect_core.sv
tb/battery_voltage_average_low_detect_core_test.sv
